/* hw/rtl/nonzero_activation_fetch_macros.svh */
// ----------------------------------------------------------------------------
// nonzero_activation_fetch_macros.svh
// Assertion helpers used by the fetcher's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef NONZERO_ACTIVATION_FETCH_MACROS_SVH
`define NONZERO_ACTIVATION_FETCH_MACROS_SVH

// plain clocked property, disabled while in reset
`define NAF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in this cycle implies expression in the next one
`define NAF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* hw/rtl/naf_pkg.sv */
// ----------------------------------------------------------------------------
// naf_pkg
// Types, constants and helpers of the nonzero activation fetcher.
// ----------------------------------------------------------------------------
package naf_pkg;

   // lane count is fixed by the four activation ports
   localparam int NUM_LANES           = 4;
   localparam int LANE_W              = 2;
   localparam int ACT_W               = 32;
   localparam int IDX_W               = 14;
   localparam int ADDR_PORT_W         = 12;
   localparam int FIFO_DEPTH_DEF      = 8;
   localparam int GROUP_ADDR_BITS_DEF = 12;
   localparam int SNAPQ_DEPTH         = 2;

   localparam logic [ACT_W-1:0] POS_INF_BITS = 32'h7F80_0000;

   typedef struct packed {
      logic [ACT_W-1:0] value;
      logic [IDX_W-1:0] index;
   } fifo_entry_type;

   // per-PE status sampled before the update
   typedef struct packed {
      logic [ACT_W-1:0] value;
      logic [IDX_W-1:0] index;
      logic             empty;
      logic             full;
   } pe_stat_type;

   // everything one accepted beat reports
   typedef struct packed {
      pe_stat_type [NUM_LANES-1:0] pe;
      logic                        group_taken;
   } snap_type;

   // per-PE FIFO control from the front
   typedef struct packed {
      logic step;
      logic write;
      logic pop;
   } fifo_ctl_type;

   // sign clear, nonzero, not NaN
   function automatic logic is_positive(input logic [ACT_W-1:0] w);
      return (w != '0) && (w <= POS_INF_BITS);
   endfunction

endpackage

/* hw/rtl/naf_pe_fifo.sv */
// ----------------------------------------------------------------------------
// naf_pe_fifo
// One PE activation FIFO with a registered head and one slot kept free.
// ----------------------------------------------------------------------------
module naf_pe_fifo #(
   parameter int FIFO_DEPTH = naf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  naf_pkg::fifo_ctl_type   ctl,
   input  naf_pkg::fifo_entry_type wdata,
   output naf_pkg::pe_stat_type    stat
);
   import naf_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_DEPTH-1:0] valid_ff, valid_in;
   fifo_entry_type        head_ff;
   fifo_entry_type        mem [FIFO_DEPTH];
   logic                  empty, full, do_write, do_pop, bypass;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // occupancy
   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (ptr_next(wr_ptr_ff) == rd_ptr_ff);
   assign do_write = ctl.step & ctl.write;
   assign do_pop   = ctl.step & ctl.pop & ~empty;

   // pointer and valid-bit update
   always_comb begin
      wr_ptr_in = do_write ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      valid_in  = valid_ff;
      if (do_write) begin
         valid_in[wr_ptr_ff] = 1'b1;
      end
   end

   // new head lands in the slot being written
   assign bypass = do_write && (wr_ptr_ff == rd_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         valid_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         valid_ff  <= valid_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   // registered head read; an unwritten slot reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (ctl.step) begin
         if (bypass) begin
            head_ff <= wdata;
         end else if (valid_ff[rd_ptr_in]) begin
            head_ff <= mem[rd_ptr_in];
         end else begin
            head_ff <= '0;
         end
      end
   end

   assign stat.value = head_ff.value;
   assign stat.index = head_ff.index;
   assign stat.empty = empty;
   assign stat.full  = full;

endmodule

/* hw/rtl/naf_front.sv */
// ----------------------------------------------------------------------------
// naf_front
// Takes a beat, scans the held group, feeds the PE FIFOs, builds the report.
// ----------------------------------------------------------------------------
module naf_front #(
   parameter int FIFO_DEPTH      = naf_pkg::FIFO_DEPTH_DEF,
   parameter int GROUP_ADDR_BITS = naf_pkg::GROUP_ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_push,
   input  logic [naf_pkg::ADDR_PORT_W-1:0]   in_group_addr,
   input  logic [naf_pkg::ACT_W-1:0]         in_act [naf_pkg::NUM_LANES],
   input  logic [naf_pkg::NUM_LANES-1:0]     in_valid_mask,
   input  logic [naf_pkg::NUM_LANES-1:0]     in_read_mask,
   input  logic                              q_full,
   output logic                              q_push,
   output naf_pkg::snap_type                 q_data
);
   import naf_pkg::*;

   localparam int PROD_W = GROUP_ADDR_BITS + LANE_W + 1;
   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);

   logic [LANE_W-1:0]          scan_pos_ff, scan_pos_in;
   logic [GROUP_ADDR_BITS-1:0] held_addr_ff;
   logic [ACT_W-1:0]           held_acts_ff [NUM_LANES];
   pe_stat_type                stat [NUM_LANES];
   fifo_ctl_type               ctl [NUM_LANES];
   fifo_entry_type             wdata;
   logic [LANE_W-1:0]          start, pos;
   logic [PROD_W-1:0]          prod;
   logic                       step, found, any_full, take_group, write_en, shift;

   assign step   = in_push & ~q_full;
   assign q_push = step;

   // scan start wraps to lane 0 after the highest lane
   assign start = (scan_pos_ff == LAST_LANE) ? '0 : scan_pos_ff + 1'b1;

   // first positive word at or after the start lane
   always_comb begin
      found = 1'b0;
      pos   = LAST_LANE;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (!found && (LANE_W'(i) >= start) && is_positive(held_acts_ff[i])) begin
            found = 1'b1;
            pos   = LANE_W'(i);
         end
      end
   end

   always_comb begin
      any_full = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         any_full = any_full | stat[i].full;
      end
   end

   // decisions
   assign take_group  = ~found | ((pos == LAST_LANE) & ~any_full);
   assign write_en    = found & ~any_full;
   assign shift       = ~(any_full & found);
   assign scan_pos_in = shift ? pos : scan_pos_ff;

   // broadcast word and its activation index
   assign prod        = PROD_W'(held_addr_ff) * PROD_W'(NUM_LANES) + PROD_W'(pos);
   assign wdata.value = held_acts_ff[pos];
   assign wdata.index = IDX_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff  <= '0;
         held_addr_ff <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            held_acts_ff[i] <= '0;
         end
      end else if (step) begin
         scan_pos_ff <= scan_pos_in;
         if (take_group) begin
            held_addr_ff <= GROUP_ADDR_BITS'(in_group_addr);
            for (int i = 0; i < NUM_LANES; i++) begin
               held_acts_ff[i] <= in_act[i];
            end
         end
      end
   end

   // PE FIFOs
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_pe
      assign ctl[g].step  = step;
      assign ctl[g].write = write_en;
      assign ctl[g].pop   = ~in_valid_mask[g] | in_read_mask[g];

      naf_pe_fifo #(
         .FIFO_DEPTH (FIFO_DEPTH)
      ) u_fifo (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[g]),
         .wdata (wdata),
         .stat  (stat[g])
      );

      assign q_data.pe[g] = stat[g];
   end

   assign q_data.group_taken = take_group;

endmodule

/* hw/rtl/naf_snap_queue.sv */
// ----------------------------------------------------------------------------
// naf_snap_queue
// Short queue of per-beat reports between the front and the result side.
// ----------------------------------------------------------------------------
module naf_snap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  naf_pkg::snap_type push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output naf_pkg::snap_type pop_data
);
   import naf_pkg::*;

   localparam int PTR_W = $clog2(SNAPQ_DEPTH);
   localparam int CNT_W = $clog2(SNAPQ_DEPTH + 1);

   snap_type          slots [SNAPQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(SNAPQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(SNAPQ_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;
   assign pop_data = slots[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/naf_back.sv */
// ----------------------------------------------------------------------------
// naf_back
// Holds one report and hands it out as one result beat per PE.
// ----------------------------------------------------------------------------
module naf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  naf_pkg::snap_type            q_data,
   output logic                         q_pop,
   input  logic                         out_pop,
   output logic                         out_empty,
   output logic [naf_pkg::LANE_W-1:0]   out_pe_id,
   output logic [naf_pkg::ACT_W-1:0]    out_head_value,
   output logic [naf_pkg::IDX_W-1:0]    out_head_index,
   output logic                         out_head_empty,
   output logic                         out_fifo_full,
   output logic                         out_group_taken,
   output logic                         out_last
);
   import naf_pkg::*;

   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);

   snap_type          snap_ff;
   logic [LANE_W-1:0] lane_ff;
   logic              busy_ff;
   logic              beat, last_beat, load;
   pe_stat_type       cur;

   assign beat      = busy_ff & out_pop;
   assign last_beat = beat & (lane_ff == LAST_LANE);
   assign load      = q_valid & (~busy_ff | last_beat);
   assign q_pop     = load;

   // lane sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         lane_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         lane_ff <= '0;
      end else if (last_beat) begin
         busy_ff <= 1'b0;
      end else if (beat) begin
         lane_ff <= lane_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= q_data;
      end
   end

   // result beat
   assign cur             = snap_ff.pe[lane_ff];
   assign out_empty       = ~busy_ff;
   assign out_pe_id       = lane_ff;
   assign out_head_value  = cur.value;
   assign out_head_index  = cur.index;
   assign out_head_empty  = cur.empty;
   assign out_fifo_full   = cur.full;
   assign out_group_taken = snap_ff.group_taken;
   assign out_last        = (lane_ff == LAST_LANE);

endmodule

/* hw/rtl/nonzero_activation_fetch.sv */
// ----------------------------------------------------------------------------
// nonzero_activation_fetch
// Sparse activation fetcher: finds positive words, feeds four PE FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (req_*): one beat is a group of four activation words with
//   its address plus the PE valid and read masks. The beat is taken when
//   req_push is high and req_full is low; the front then updates the scan,
//   the held group and the PE FIFOs.
//   Result queue (rsp_*): each beat yields four result beats, PE 0 first,
//   rsp_last on PE 3. They report each PE FIFO head, empty and full before
//   the update, plus whether the offered group was latched.
//   Path: an accepted beat goes into the report queue, then the result register.
//   Throughput: the single result port moves one result a cycle while rsp_pop
//   is high, and each item takes four result beats; a two-entry report queue plus the
//   result register absorb a burst of three back-to-back items.
//   Stall: when rsp_pop stays low the report queue fills and req_full rises;
//   no beat is lost or repeated.
//   Reset: synchronous; clears the scan position, held group, FIFO pointers,
//   valid bits and both queues. Unwritten FIFO slots read as zero.
// ----------------------------------------------------------------------------
`include "nonzero_activation_fetch_macros.svh"

module nonzero_activation_fetch #(
   parameter int FIFO_DEPTH      = naf_pkg::FIFO_DEPTH_DEF,
   parameter int GROUP_ADDR_BITS = naf_pkg::GROUP_ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [naf_pkg::ADDR_PORT_W-1:0]   req_group_addr,
   input  logic [naf_pkg::ACT_W-1:0]         req_act_0,
   input  logic [naf_pkg::ACT_W-1:0]         req_act_1,
   input  logic [naf_pkg::ACT_W-1:0]         req_act_2,
   input  logic [naf_pkg::ACT_W-1:0]         req_act_3,
   input  logic [naf_pkg::NUM_LANES-1:0]     req_pe_valid_mask,
   input  logic [naf_pkg::NUM_LANES-1:0]     req_pe_read_mask,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [naf_pkg::LANE_W-1:0]        rsp_pe_id,
   output logic [naf_pkg::ACT_W-1:0]         rsp_head_value,
   output logic [naf_pkg::IDX_W-1:0]         rsp_head_index,
   output logic                              rsp_head_empty,
   output logic                              rsp_fifo_full,
   output logic                              rsp_group_taken,
   output logic                              rsp_last
);
   import naf_pkg::*;

   logic [ACT_W-1:0] req_act [NUM_LANES];
   snap_type         push_data, pop_data;
   logic             q_push, q_full, q_valid, q_pop;

   assign req_act[0] = req_act_0;
   assign req_act[1] = req_act_1;
   assign req_act[2] = req_act_2;
   assign req_act[3] = req_act_3;
   assign req_full   = q_full;

   naf_front #(
      .FIFO_DEPTH      (FIFO_DEPTH),
      .GROUP_ADDR_BITS (GROUP_ADDR_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_push       (req_push),
      .in_group_addr (req_group_addr),
      .in_act        (req_act),
      .in_valid_mask (req_pe_valid_mask),
      .in_read_mask  (req_pe_read_mask),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (push_data)
   );

   naf_snap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (pop_data)
   );

   naf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (pop_data),
      .q_pop           (q_pop),
      .out_pop         (rsp_pop),
      .out_empty       (rsp_empty),
      .out_pe_id       (rsp_pe_id),
      .out_head_value  (rsp_head_value),
      .out_head_index  (rsp_head_index),
      .out_head_empty  (rsp_head_empty),
      .out_fifo_full   (rsp_fifo_full),
      .out_group_taken (rsp_group_taken),
      .out_last        (rsp_last)
   );

   // once an accepted beat has passed the report queue, the result side is not empty
   `NAF_ASSERT(a_accept_reaches_rsp, clock, reset, (req_push && !req_full) |-> ##2 !rsp_empty, "accepted beat did not reach result side")

   // within a report the PE number steps and the group flag holds
   `NAF_ASSERT_NEXT(a_lane_steps, clock, reset, !rsp_empty && rsp_pop && !rsp_last, !rsp_empty && rsp_pe_id == LANE_W'($past(rsp_pe_id) + 1'b1) && $stable(rsp_group_taken), "result lanes out of order")

   // last beat with nothing queued leaves the result side empty
   `NAF_ASSERT_NEXT(a_drain_empty, clock, reset, !rsp_empty && rsp_pop && rsp_last && !q_valid, rsp_empty, "result side not empty after drain")

endmodule
